@@ rtl/rgb565_tint_alpha_compositor_unit_macros.svh @@
// assertion macros for the rgb565 tint/alpha compositor
// used only by the top level, which owns the clock and reset it passes in

`ifndef RGB565_TINT_ALPHA_COMPOSITOR_UNIT_MACROS_SVH
`define RGB565_TINT_ALPHA_COMPOSITOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTAC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("rtac: implication check failed");

// next-cycle implication, checked outside reset
`define RTAC_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("rtac: next-cycle check failed");

`endif

@@ rtl/rtac_pkg.sv @@
// shared types and constants of the rgb565 tint/alpha compositor
// no dependencies; imported by rtac_channel and the top level

package rtac_pkg;

	// request and result payloads
	typedef struct packed {
		logic [15:0] foreground_pixel;
		logic        foreground_visible;
		logic [15:0] background_pixel;
	} rtac_in_t;

	typedef struct packed {
		logic [15:0] result_pixel;
		logic        write_enable;
	} rtac_out_t;

	// register indexes
	localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
	localparam logic [1:0] REG_ALPHA_LEVEL = 2'd1;
	localparam logic [1:0] REG_TINT_COLOR  = 2'd2;
	localparam logic [1:0] REG_MASK_ENABLE = 2'd3;

	// blend modes
	localparam logic [1:0] MODE_COPY  = 2'd0;
	localparam logic [1:0] MODE_FADE  = 2'd1;
	localparam logic [1:0] MODE_BLEND = 2'd2;
	localparam logic [1:0] MODE_TINT  = 2'd3;

	// output select carried down the pipe
	localparam logic [1:0] SEL_COPY  = 2'd0;
	localparam logic [1:0] SEL_FADE  = 2'd1;
	localparam logic [1:0] SEL_KEEP  = 2'd2;
	localparam logic [1:0] SEL_BLEND = 2'd3;

	localparam logic [15:0] FADE_MASK = 16'h7BEF;

	// floor(x/10) = (x*205) >> 11, exact for x below 1024
	localparam logic [7:0] TINT_RECIP = 8'd205;
	localparam int         TINT_SHIFT = 11;

	localparam logic [7:0] ALPHA_FULL = 8'd255;

endpackage

@@ rtl/rgb565_tint_alpha_compositor_unit.sv @@
// rgb565 pixel compositor: masked copy, fade, alpha blend, tinted alpha blend
// a pixel taken on start passes registers s1 to s4 and shows on result, with result_valid
// throughput: one pixel per clock; the four-stage datapath (tint sum, divide by ten,
// weight multiply, divide by 255 into the output register) accepts a pixel every cycle
// busy stays low; the receiver takes each result in its single cycle, nothing waits
// reset: pipeline valids clear, registers go to copy mode, alpha 255, tint 0, mask off

module rgb565_tint_alpha_compositor_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rtac_pkg::rtac_in_t  request,
	output rtac_pkg::rtac_out_t result,
	output logic                result_valid,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);
	import rtac_pkg::*;

	`include "rgb565_tint_alpha_compositor_unit_macros.svh"

	// configuration registers
	logic [1:0]  blend_mode_q;
	logic [7:0]  alpha_level_q;
	logic [15:0] tint_color_q;
	logic        mask_enable_q;

	// transfer handshake
	logic accept;

	// routing decision made at entry
	logic [1:0] sel_in;

	// control and bypass payload traveling beside the channel datapaths
	logic        v_s1, v_s2, v_s3;
	logic [1:0]  sel_s1, sel_s2, sel_s3;
	logic [15:0] fg_s1, fg_s2, fg_s3;
	logic [15:0] bg_s1, bg_s2, bg_s3;

	// per-channel blend results, valid alongside s3
	logic [4:0] blend_r;
	logic [5:0] blend_g;
	logic [4:0] blend_b;

	// final pick before the output register
	rtac_out_t  res_d;
	rtac_out_t  res_s4;
	logic       v_s4;

	// no internal back-pressure: every stage moves every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// register writes; the user must write only while the pipe is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q  <= MODE_COPY;
			alpha_level_q <= ALPHA_FULL;
			tint_color_q  <= '0;
			mask_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND_MODE:  blend_mode_q  <= cfg_wdata[1:0];
				REG_ALPHA_LEVEL: alpha_level_q <= cfg_wdata[7:0];
				REG_TINT_COLOR:  tint_color_q  <= cfg_wdata;
				REG_MASK_ENABLE: mask_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// fade ignores the mask; the other modes keep the background when masked out
	always_comb begin
		case (blend_mode_q)
			MODE_FADE:  sel_in = SEL_FADE;
			MODE_COPY:  sel_in = (mask_enable_q && !request.foreground_visible) ?
			                     SEL_KEEP : SEL_COPY;
			MODE_BLEND: sel_in = (mask_enable_q && !request.foreground_visible) ?
			                     SEL_KEEP : SEL_BLEND;
			MODE_TINT:  sel_in = (mask_enable_q && !request.foreground_visible) ?
			                     SEL_KEEP : SEL_BLEND;
			default:    sel_in = SEL_COPY;
		endcase
	end

	// valid bits ride with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// bypass payload, no reset needed
	always_ff @(posedge clk) begin
		sel_s1 <= sel_in;
		fg_s1  <= request.foreground_pixel;
		bg_s1  <= request.background_pixel;
		sel_s2 <= sel_s1;
		fg_s2  <= fg_s1;
		bg_s2  <= bg_s1;
		sel_s3 <= sel_s2;
		fg_s3  <= fg_s2;
		bg_s3  <= bg_s2;
	end

	// red in bits 4:0, green in 10:5, blue in 15:11
	rtac_channel #(.W(5)) u_chan_r (
		.clk      (clk),
		.fg       (request.foreground_pixel[4:0]),
		.bg       (request.background_pixel[4:0]),
		.tint     (tint_color_q[4:0]),
		.alpha    (alpha_level_q),
		.use_tint (blend_mode_q == MODE_TINT),
		.blend    (blend_r)
	);

	rtac_channel #(.W(6)) u_chan_g (
		.clk      (clk),
		.fg       (request.foreground_pixel[10:5]),
		.bg       (request.background_pixel[10:5]),
		.tint     (tint_color_q[10:5]),
		.alpha    (alpha_level_q),
		.use_tint (blend_mode_q == MODE_TINT),
		.blend    (blend_g)
	);

	rtac_channel #(.W(5)) u_chan_b (
		.clk      (clk),
		.fg       (request.foreground_pixel[15:11]),
		.bg       (request.background_pixel[15:11]),
		.tint     (tint_color_q[15:11]),
		.alpha    (alpha_level_q),
		.use_tint (blend_mode_q == MODE_TINT),
		.blend    (blend_b)
	);

	// output select
	always_comb begin
		case (sel_s3)
			SEL_FADE: begin
				res_d.result_pixel = (bg_s3 >> 1) & FADE_MASK;
				res_d.write_enable = 1'b1;
			end
			SEL_KEEP: begin
				res_d.result_pixel = bg_s3;
				res_d.write_enable = 1'b0;
			end
			SEL_BLEND: begin
				res_d.result_pixel = {blend_b, blend_g, blend_r};
				res_d.write_enable = 1'b1;
			end
			default: begin
				res_d.result_pixel = fg_s3;
				res_d.write_enable = 1'b1;
			end
		endcase
	end

	// output register; each result is shown for exactly one cycle
	always_ff @(posedge clk) begin
		res_s4 <= res_d;
	end

	assign result       = res_s4;
	assign result_valid = v_s4;

	// every accepted pixel comes out with result_valid
	`RTAC_ASSERT_IMP(a_latency, clk, arst_n, accept, ##4 result_valid)
	// no result without an accepted pixel behind it
	`RTAC_ASSERT_IMP(a_no_phantom, clk, arst_n, result_valid, $past(accept, 4))
	// a masked-out result hands back the background it came with
	`RTAC_ASSERT_IMP(a_keep_bg, clk, arst_n, result_valid && !result.write_enable,
		result.result_pixel == $past(request.background_pixel, 4))

endmodule

@@ rtl/rtac_channel.sv @@
// one color channel of the compositor datapath: tint, then alpha mix
// three register stages; uses rtac_pkg constants

module rtac_channel #(
	parameter int W = 5
) (
	input  logic         clk,
	input  logic [W-1:0] fg,
	input  logic [W-1:0] bg,
	input  logic [W-1:0] tint,
	input  logic [7:0]   alpha,
	input  logic         use_tint,
	output logic [W-1:0] blend
);
	import rtac_pkg::*;

	localparam int SW = W + 4;   // holds 10 * max channel
	localparam int PW = SW + 8;  // sum times 8-bit reciprocal
	localparam int MW = W + 8;   // channel times 8-bit weight

	logic [SW-1:0] fg_x;
	logic [SW-1:0] t_x;
	logic [PW-1:0] prod;
	logic [W-1:0]  tinted;
	logic [MW:0]   rnd;

	logic [SW-1:0] sum_s1;
	logic [W-1:0]  fg_s1;
	logic [W-1:0]  bg_s1;
	logic [7:0]    alpha_s1;
	logic          use_tint_s1;

	logic [W-1:0]  fsel_s2;
	logic [W-1:0]  bg_s2;
	logic [7:0]    alpha_s2;

	logic [MW-1:0] mix_s3;

	assign fg_x = SW'(fg);
	assign t_x  = SW'(tint);

	// s1: 7c + 3t
	always_ff @(posedge clk) begin
		sum_s1      <= (fg_x << 3) - fg_x + (t_x << 1) + t_x;
		fg_s1       <= fg;
		bg_s1       <= bg;
		alpha_s1    <= alpha;
		use_tint_s1 <= use_tint;
	end

	// s2: divide by ten through the reciprocal
	assign prod   = PW'(sum_s1) * PW'(TINT_RECIP);
	assign tinted = prod[TINT_SHIFT +: W];

	always_ff @(posedge clk) begin
		fsel_s2  <= use_tint_s1 ? tinted : fg_s1;
		bg_s2    <= bg_s1;
		alpha_s2 <= alpha_s1;
	end

	// s3: b*(255-a) + f*a
	always_ff @(posedge clk) begin
		mix_s3 <= MW'(bg_s2) * MW'(ALPHA_FULL - alpha_s2) + MW'(fsel_s2) * MW'(alpha_s2);
	end

	// floor(x/255) = (x + (x>>8) + 1) >> 8 over this range
	assign rnd   = {1'b0, mix_s3} + (MW + 1)'(mix_s3 >> 8) + (MW + 1)'(1);
	assign blend = rnd[8 +: W];

endmodule

@@ tb/sv/tb_rgb565_tint_alpha_compositor_unit.sv @@
// testbench for the rgb565 tint/alpha compositor: directed and random pixel transfers,
// each result checked against an in-bench prediction of the four compositing modes
// depends on rtac_pkg and rgb565_tint_alpha_compositor_unit only
`timescale 1ns / 100ps

module tb_rgb565_tint_alpha_compositor_unit;
	import rtac_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run
	localparam int SETTLE_TICKS = 12;      // pipeline depth is four, leave slack

	// what the driver pulls off its queue
	typedef enum logic [1:0] {
		JOB_PIXEL,      // one pixel transfer
		JOB_REG_WRITE,  // register write, only once the pipe has drained
		JOB_DRAIN,      // hold off until every pending result is back
		JOB_GAP         // change how often the driver sits idle
	} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		rtac_in_t    pixel;
		logic [1:0]  reg_index;
		logic [15:0] reg_value;
		int          gap_pct;
	} pixel_job_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	rtac_in_t    request = '0;
	rtac_out_t   result;
	logic        result_valid;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_BLEND_MODE;
	logic [15:0] cfg_wdata = 16'h0000;

	pixel_job_t  job_q[$];
	rtac_out_t   composite_q[$];   // predicted results, oldest first
	int          gap_pct = 0;
	bit          taken = 1'b0;     // set at the edge that accepts a transfer
	int          err_count = 0;
	int          cycle_count = 0;

	// shadow copy of the block's registers, reset values
	logic [1:0]  mode_reg = MODE_COPY;
	logic [7:0]  alpha_reg = 8'd255;
	logic [15:0] tint_reg = 16'h0000;
	logic        mask_reg = 1'b0;

	rgb565_tint_alpha_compositor_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result       (result),
		.result_valid (result_valid),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------------------

	// 30 percent tint: floor((7c + 3t) / 10)
	function automatic logic [5:0] tint_chan(logic [5:0] c, logic [5:0] t);
		int unsigned q;
		q = (7 * c + 3 * t) / 10;
		return q[5:0];
	endfunction

	// weighted mix: floor((b*(255-a) + f*a) / 255)
	function automatic logic [5:0] mix_chan(logic [5:0] f, logic [5:0] b, logic [7:0] a);
		int unsigned q;
		q = (b * (255 - a) + f * a) / 255;
		return q[5:0];
	endfunction

	function automatic rtac_out_t composite_pixel(rtac_in_t px, logic [1:0] mode,
			logic [7:0] alpha, logic [15:0] tint, logic mask_on);
		rtac_out_t   r;
		logic [15:0] fg;
		logic [15:0] bg;
		logic [5:0]  red;
		logic [5:0]  grn;
		logic [5:0]  blu;
		fg = px.foreground_pixel;
		bg = px.background_pixel;
		r.write_enable = 1'b1;
		if (mode == MODE_FADE) begin
			// fade never looks at the mask
			r.result_pixel = (bg >> 1) & FADE_MASK;
		end else if (mask_on && !px.foreground_visible) begin
			// masked out: background passes through, no write
			r.result_pixel = bg;
			r.write_enable = 1'b0;
		end else if (mode == MODE_COPY) begin
			r.result_pixel = fg;
		end else begin
			if (mode == MODE_TINT) begin
				red = tint_chan(fg[4:0], tint[4:0]);
				grn = tint_chan(fg[10:5], tint[10:5]);
				blu = tint_chan(fg[15:11], tint[15:11]);
				fg = {blu[4:0], grn, red[4:0]};
			end
			red = mix_chan(fg[4:0], bg[4:0], alpha);
			grn = mix_chan(fg[10:5], bg[10:5], alpha);
			blu = mix_chan(fg[15:11], bg[15:11], alpha);
			r.result_pixel = {blu[4:0], grn, red[4:0]};
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [16:0] want, logic [16:0] got);
		$display("mismatch @%0d: %s want %h got %h", cycle_count, what, want, got);
		err_count++;
	endtask

	// ---------------------------------------------------------------------------
	// monitor: samples at the rising edge
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin : watch_results
		rtac_out_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else if (arst_n) begin
			// accepted transfer: predict with the registers as they stand now
			if (start && !busy) begin
				composite_q.push_back(composite_pixel(request, mode_reg, alpha_reg,
					tint_reg, mask_reg));
				taken = 1'b1;
			end
			// register writes only happen while idle, so ordering with the
			// prediction above cannot matter
			if (cfg_we) begin
				case (cfg_index)
					REG_BLEND_MODE:  mode_reg = cfg_wdata[1:0];
					REG_ALPHA_LEVEL: alpha_reg = cfg_wdata[7:0];
					REG_TINT_COLOR:  tint_reg = cfg_wdata;
					REG_MASK_ENABLE: mask_reg = cfg_wdata[0];
					default: ;
				endcase
			end
			if (result_valid) begin
				if (composite_q.size() == 0) begin
					flag_mismatch("result with nothing pending", 17'h0, result);
				end else begin
					want = composite_q.pop_front();
					if (result.result_pixel !== want.result_pixel)
						flag_mismatch("result_pixel", {1'b0, want.result_pixel},
							{1'b0, result.result_pixel});
					if (result.write_enable !== want.write_enable)
						flag_mismatch("write_enable", {16'h0, want.write_enable},
							{16'h0, result.write_enable});
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// driver: changes inputs at the falling edge, one assignment per signal
	// ---------------------------------------------------------------------------
	always @(negedge clk) begin : drive_requests
		logic        go;
		logic        wr;
		rtac_in_t    px;
		logic [1:0]  idx;
		logic [15:0] wd;
		go = 1'b0;
		wr = 1'b0;
		px = request;
		idx = cfg_index;
		wd = cfg_wdata;
		if (!arst_n) begin
			go = 1'b0;
		end else if (start && !taken) begin
			// block is busy, keep the transfer on the port
			go = 1'b1;
		end else begin
			taken = 1'b0;
			// gap changes take effect right away
			while (job_q.size() > 0 && job_q[0].kind == JOB_GAP) begin
				gap_pct = job_q[0].gap_pct;
				void'(job_q.pop_front());
			end
			if (job_q.size() > 0) begin
				case (job_q[0].kind)
					JOB_PIXEL: begin
						if ($urandom_range(0, 99) >= gap_pct) begin
							go = 1'b1;
							px = job_q[0].pixel;
							void'(job_q.pop_front());
						end
					end
					JOB_REG_WRITE: begin
						// only with the pipe empty and nothing on the port
						if (composite_q.size() == 0 && !start && !cfg_we) begin
							wr = 1'b1;
							idx = job_q[0].reg_index;
							wd = job_q[0].reg_value;
							void'(job_q.pop_front());
						end
					end
					JOB_DRAIN: begin
						if (composite_q.size() == 0 && !start)
							void'(job_q.pop_front());
					end
					default: void'(job_q.pop_front());
				endcase
			end
		end
		start <= go;
		request <= px;
		cfg_we <= wr;
		cfg_index <= idx;
		cfg_wdata <= wd;
	end

	// ---------------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------------
	task automatic queue_pixel(logic [15:0] fg, logic vis, logic [15:0] bg);
		pixel_job_t j;
		j.kind = JOB_PIXEL;
		j.pixel.foreground_pixel = fg;
		j.pixel.foreground_visible = vis;
		j.pixel.background_pixel = bg;
		j.reg_index = REG_BLEND_MODE;
		j.reg_value = 16'h0;
		j.gap_pct = 0;
		job_q.push_back(j);
	endtask

	task automatic queue_reg_write(logic [1:0] idx, logic [15:0] val);
		pixel_job_t j;
		j.kind = JOB_REG_WRITE;
		j.pixel = '0;
		j.reg_index = idx;
		j.reg_value = val;
		j.gap_pct = 0;
		job_q.push_back(j);
	endtask

	task automatic queue_marker(job_kind_t kind, int pct);
		pixel_job_t j;
		j.kind = kind;
		j.pixel = '0;
		j.reg_index = REG_BLEND_MODE;
		j.reg_value = 16'h0;
		j.gap_pct = pct;
		job_q.push_back(j);
	endtask

	// mostly random, with black and white now and then
	function automatic logic [15:0] pick_pixel();
		logic [15:0] p;
		case ($urandom_range(0, 7))
			0: p = 16'h0000;
			1: p = 16'hFFFF;
			default: p = 16'($urandom);
		endcase
		return p;
	endfunction

	function automatic logic [7:0] pick_alpha();
		logic [7:0] a;
		case ($urandom_range(0, 5))
			0: a = 8'd0;
			1: a = 8'd255;
			default: a = 8'($urandom);
		endcase
		return a;
	endfunction

	initial begin : run_test
		int          phase_gap[3];
		logic [1:0]  mode;
		int          run_len;
		phase_gap[0] = 38;
		phase_gap[1] = 83;
		phase_gap[2] = 0;

		// directed part, back to back
		queue_marker(JOB_GAP, 0);
		// reset state: copy, mask off, visibility ignored
		queue_pixel(16'hFFFF, 1'b0, 16'h0000);
		queue_pixel(16'h0000, 1'b1, 16'hFFFF);
		// copy with the mask on, both mask bit values
		queue_reg_write(REG_MASK_ENABLE, 16'h0001);
		queue_pixel(16'hA5C3, 1'b0, 16'h5A3C);
		queue_pixel(16'hA5C3, 1'b1, 16'h5A3C);
		// fade halves every channel and ignores the mask
		queue_reg_write(REG_BLEND_MODE, {14'h0, MODE_FADE});
		queue_pixel(16'h1234, 1'b0, 16'hFFFF);
		queue_pixel(16'hFFFF, 1'b1, 16'h8421);
		// plain blend at both alpha extremes and at the midpoint
		queue_reg_write(REG_BLEND_MODE, {14'h0, MODE_BLEND});
		queue_reg_write(REG_ALPHA_LEVEL, 16'h0000);
		queue_pixel(16'hFFFF, 1'b1, 16'h0000);
		queue_reg_write(REG_ALPHA_LEVEL, 16'h00FF);
		queue_pixel(16'hFFFF, 1'b1, 16'h0000);
		queue_pixel(16'h0000, 1'b1, 16'hFFFF);
		queue_reg_write(REG_ALPHA_LEVEL, 16'h0080);
		queue_pixel(16'hFFFF, 1'b1, 16'h0000);
		queue_pixel(16'h0000, 1'b1, 16'hFFFF);
		queue_pixel(16'hFFFF, 1'b0, 16'h0841);   // masked out
		// tinted blend: tint extremes, alpha extremes
		queue_reg_write(REG_BLEND_MODE, {14'h0, MODE_TINT});
		queue_reg_write(REG_TINT_COLOR, 16'hFFFF);
		queue_reg_write(REG_ALPHA_LEVEL, 16'h00FF);
		queue_pixel(16'h0000, 1'b1, 16'h0000);
		queue_pixel(16'hFFFF, 1'b1, 16'h0000);
		queue_pixel(16'hFFFF, 1'b0, 16'h7BEF);   // masked out
		queue_reg_write(REG_TINT_COLOR, 16'h0000);
		queue_pixel(16'hFFFF, 1'b1, 16'h0000);
		queue_reg_write(REG_TINT_COLOR, 16'hF81F);
		queue_reg_write(REG_ALPHA_LEVEL, 16'h0000);
		queue_pixel(16'h07E0, 1'b1, 16'hFFFF);
		// junk in the upper write-data bits must be dropped
		queue_reg_write(REG_ALPHA_LEVEL, 16'hFF4D);
		queue_reg_write(REG_MASK_ENABLE, 16'hFFFE);
		queue_pixel(16'h9E73, 1'b0, 16'h318C);   // mask off, drawn anyway

		// random part: three pacing phases, registers reshuffled between runs
		for (int ph = 0; ph < 3; ph++) begin
			queue_marker(JOB_GAP, phase_gap[ph]);
			for (int seg = 0; seg < 9; seg++) begin
				mode = 2'($urandom_range(0, 3));
				queue_reg_write(REG_BLEND_MODE, {14'($urandom), mode});
				queue_reg_write(REG_ALPHA_LEVEL, {8'($urandom), pick_alpha()});
				queue_reg_write(REG_TINT_COLOR, pick_pixel());
				queue_reg_write(REG_MASK_ENABLE, {15'($urandom), 1'($urandom)});
				run_len = $urandom_range(20, 40);
				for (int i = 0; i < run_len; i++) begin
					// sender sits out until the pipe is empty once per phase
					if (seg == 4 && i == run_len / 2)
						queue_marker(JOB_DRAIN, 0);
					queue_pixel(pick_pixel(), 1'($urandom), pick_pixel());
				end
			end
		end

		// hold reset, then release it away from the rising edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// run until every transfer is on its way and every result back
		while (job_q.size() != 0 || start || composite_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		@(negedge clk);
		while (composite_q.size() != 0)
			flag_mismatch("result never arrived", composite_q.pop_front(), 17'h0);

		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
